/* hw/rtl/mmfn_pkg.sv */
// Shared types and constants of the min-max feature normaliser.
`default_nettype none
package mmfn_pkg;
	localparam int COLUMNS = 16;
	localparam int FRACTION_BITS = 15;
	localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int CNT_W = $clog2(FRACTION_BITS + 1);
	localparam int QDEPTH = 2;

	localparam logic [1:0] CMD_CLEAR     = 2'd0;
	localparam logic [1:0] CMD_OBSERVE   = 2'd1;
	localparam logic [1:0] CMD_NORMALISE = 2'd2;

	// decoded job from front to back
	typedef struct packed {
		logic              trivial;  // answer already known
		logic [15:0]       scaled;
		logic              unseen;
		logic              clipped;
		logic [16:0]       diff;     // sample - min
		logic [16:0]       span;     // max - min
	} job_t;

	typedef struct packed {
		logic [15:0] scaled;
		logic        column_unseen;
		logic        clipped;
	} res_t;
endpackage
`default_nettype wire

/* hw/rtl/mmfn_if.sv */
// Valid/ready channel interfaces for input and result words.
`default_nettype none
interface mmfn_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [3:0]  column;
	logic signed [15:0] sample;
	modport source (output valid, command, column, sample, input ready);
	modport sink (input valid, command, column, sample, output ready);
endinterface

interface mmfn_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] scaled;
	logic        column_unseen;
	logic        clipped;
	modport source (output valid, scaled, column_unseen, clipped, input ready);
	modport sink (input valid, scaled, column_unseen, clipped, output ready);
endinterface
`default_nettype wire

/* hw/rtl/minmax_feature_normalizer.sv */
// Top level of the min-max feature normaliser.
// channel  dir  fields
// in_ch    in   command[1:0] column[3:0] sample[15:0] signed
// out_ch   out  scaled[15:0] column_unseen clipped
// Clear and observe words never wait on the queue. A normalise word strictly below
// the top of a non-flat range passes through the radix-2 divider (load, divide,
// output); other normalise words go straight from load to output.
// Reset clears the seen bits at once. A two-entry queue lets the front
// keep observing while the back divides or its result waits.
`default_nettype none
module minmax_feature_normalizer (
	input  wire logic clk,
	input  wire logic arst_n,
	mmfn_in_if.sink   in_ch,
	mmfn_out_if.source out_ch
);
	import mmfn_pkg::*;

	job_t f_job, b_job;
	logic f_valid, f_ready, b_valid, b_ready;

	mmfn_front u_front (.clk, .arst_n, .in_ch, .job(f_job), .job_valid(f_valid),
		.job_ready(f_ready));
	mmfn_queue u_queue (.clk, .arst_n, .wr_job(f_job), .wr_valid(f_valid),
		.wr_ready(f_ready), .rd_job(b_job), .rd_valid(b_valid), .rd_ready(b_ready));
	mmfn_back u_back (.clk, .arst_n, .job(b_job), .job_valid(b_valid),
		.job_ready(b_ready), .out_ch);
endmodule
`default_nettype wire

/* hw/rtl/mmfn_front.sv */
// Front end: column statistics, command decode and job issue.
`default_nettype none
module mmfn_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	mmfn_in_if.sink              in_ch,
	output mmfn_pkg::job_t       job,
	output logic                 job_valid,
	input  wire logic            job_ready
);
	import mmfn_pkg::*;

	logic signed [15:0] min_q [COLUMNS];
	logic signed [15:0] max_q [COLUMNS];
	logic [COLUMNS-1:0] seen_q;

	logic              in_range;
	logic [IDX_W-1:0]  idx;
	logic signed [15:0] lo, hi;
	logic              acc;

	assign in_range = ({28'd0, in_ch.column} < 32'(COLUMNS));
	assign idx = IDX_W'(in_ch.column);
	assign lo = min_q[idx];
	assign hi = max_q[idx];
	// non-normalise words never wait on the queue
	assign in_ch.ready = (in_ch.command != CMD_NORMALISE) || job_ready;
	assign acc = in_ch.valid && in_ch.ready;
	assign job_valid = in_ch.valid && (in_ch.command == CMD_NORMALISE);

	// classify normalise word
	always_comb begin
		job = '0;
		job.diff = 17'(in_ch.sample) - 17'(lo);
		job.span = 17'(hi) - 17'(lo);
		if (!in_range || !seen_q[idx]) begin
			job.trivial = 1'b1;
			job.unseen = 1'b1;
		end else if (in_ch.sample < lo) begin
			job.trivial = 1'b1;
			job.clipped = 1'b1;
		end else if (in_ch.sample > hi) begin
			job.trivial = 1'b1;
			job.clipped = 1'b1;
			job.scaled = 16'((64'd1 << FRACTION_BITS) & 64'hFFFF);
		end else if (hi == lo) begin
			job.trivial = 1'b1;
		end else if (in_ch.sample == hi) begin
			// top of the range is exactly one
			job.trivial = 1'b1;
			job.scaled = 16'((64'd1 << FRACTION_BITS) & 64'hFFFF);
		end
	end

	// statistics update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (acc && in_ch.command == CMD_CLEAR) begin
			seen_q <= '0;
		end else if (acc && in_ch.command == CMD_OBSERVE && in_range) begin
			seen_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_ch.command == CMD_OBSERVE && in_range) begin
			if (!seen_q[idx] || in_ch.sample < lo) min_q[idx] <= in_ch.sample;
			if (!seen_q[idx] || in_ch.sample > hi) max_q[idx] <= in_ch.sample;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/mmfn_queue.sv */
// Short job queue between front and back.
`default_nettype none
module mmfn_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  mmfn_pkg::job_t       wr_job,
	input  wire logic            wr_valid,
	output logic                 wr_ready,
	output mmfn_pkg::job_t       rd_job,
	output logic                 rd_valid,
	input  wire logic            rd_ready
);
	import mmfn_pkg::*;

	job_t mem_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != 2'(QDEPTH));
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end
endmodule
`default_nettype wire

/* hw/rtl/mmfn_back.sv */
// Back end: restoring divider, one quotient bit a cycle, and result register.
`default_nettype none
module mmfn_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  mmfn_pkg::job_t       job,
	input  wire logic            job_valid,
	output logic                 job_ready,
	mmfn_out_if.source           out_ch
);
	import mmfn_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]  state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [16:0] rem_q;
	logic [16:0] span_q;
	logic [FRACTION_BITS-2:0] quo_q;
	res_t        res_q;
	logic [17:0] trial;

	assign job_ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.scaled = res_q.scaled;
	assign out_ch.column_unseen = res_q.column_unseen;
	assign out_ch.clipped = res_q.clipped;
	// diff < span so remainder stays below span; shifted fits 17 bits
	assign trial = {rem_q, 1'b0} - {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (job_valid) state_q <= job.trivial ? ST_OUT : ST_DIV;
				ST_DIV: if (cnt_q == CNT_W'(FRACTION_BITS - 1)) state_q <= ST_OUT;
				ST_OUT: if (out_ch.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			rem_q <= job.diff;
			span_q <= job.span;
			cnt_q <= '0;
			res_q <= '{scaled: job.scaled, column_unseen: job.unseen, clipped: job.clipped};
		end else if (state_q == ST_DIV) begin
			cnt_q <= cnt_q + 1'b1;
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[FRACTION_BITS-3:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], 1'b0};
				quo_q <= {quo_q[FRACTION_BITS-3:0], 1'b0};
			end
			if (cnt_q == CNT_W'(FRACTION_BITS - 1))
				res_q.scaled <= 16'({quo_q, ~trial[17]});
		end
	end
endmodule
`default_nettype wire
